// ===== rtl/core/periodic_event_scheduler_assert.svh =====
// ----------------------------------------------------------------------------
// periodic event scheduler assertion macros
// concurrent check wrappers, empty when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef PERIODIC_EVENT_SCHEDULER_ASSERT_SVH
`define PERIODIC_EVENT_SCHEDULER_ASSERT_SVH

`ifndef SYNTH

`define PES_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pes check failed: same cycle implication");

`define PES_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pes check failed: next cycle implication");

`else

`define PES_ASSERT_IMPLY(label, clk, rst, ante, cons)

`define PES_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ===== rtl/core/pes_pkg.sv =====
// ----------------------------------------------------------------------------
// pes_pkg
// shared types and codes of the periodic event scheduler
// ----------------------------------------------------------------------------
package pes_pkg;

   localparam int TIME_W = 48;
   localparam int ID_W   = 32;
   localparam int PER_W  = 16;

   localparam logic [1:0] FUNC_CLEAR    = 2'd0;
   localparam logic [1:0] FUNC_REGISTER = 2'd1;
   localparam logic [1:0] FUNC_NEXT     = 2'd2;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_EMPTY    = 2'd1;
   localparam logic [1:0] ST_FULL     = 2'd2;
   localparam logic [1:0] ST_OVERFLOW = 2'd3;

   // field order gives the serve order as a plain unsigned compare
   typedef struct packed {
      logic [TIME_W-1:0] due_time;
      logic [ID_W-1:0]   user_id;
      logic [PER_W-1:0]  period;
   } entry_type;

endpackage

// ===== rtl/core/pes_channels.sv =====
// ----------------------------------------------------------------------------
// pes channels
// request and response handshake channels of the scheduler
// ----------------------------------------------------------------------------
interface pes_req_if;
   logic                       valid;
   logic                       ready;
   logic [1:0]                 func;
   logic [pes_pkg::ID_W-1:0]   user_id;
   logic [pes_pkg::PER_W-1:0]  period;

   modport source (output valid, output func, output user_id, output period, input ready);
   modport sink   (input valid, input func, input user_id, input period, output ready);
endinterface

interface pes_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [pes_pkg::ID_W-1:0]   served_id;
   logic [pes_pkg::TIME_W-1:0] served_time;
   logic [1:0]                 status;

   modport source (output valid, output served_id, output served_time, output status,
                   input ready);
   modport sink   (input valid, input served_id, input served_time, input status,
                   output ready);
endinterface

// ===== rtl/core/periodic_event_scheduler.sv =====
// ----------------------------------------------------------------------------
// periodic_event_scheduler
// Periodic scheduler on a binary min-heap of up to MAX_ENTRIES entries held
// in one memory with registered reads. One request beat is taken at a time;
// the response beat is offered when the request is done and the next request
// is taken once it has been delivered. Clear, the no-op code, a register on
// a full table and a next on an empty table go straight from idle to the
// response. A register climbs the heap one level per pass (read the parent,
// then compare and write). A next reads the root and checks the new due
// time, answering with an overflow status when it would overflow, then
// sifts down one level per pass (read both children, pick one, compare with
// the moving entry). Those steps come from the single shared comparator and
// the registered reads of the heap memory. No clearing pass is needed after
// reset.
// ----------------------------------------------------------------------------
module periodic_event_scheduler #(
   parameter int MAX_ENTRIES = 64
) (
   input  logic       clock,
   input  logic       reset,
   pes_req_if.sink    req_ch,
   pes_rsp_if.source  rsp_ch
);

   localparam int ADDR_W = $clog2(MAX_ENTRIES);
   localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
   localparam int IDX_W  = ADDR_W + 2;
   localparam int TIME_W = pes_pkg::TIME_W;

   typedef enum logic [8:0] {
      S_IDLE     = 9'b000000001,
      S_UP_RD    = 9'b000000010,
      S_UP_CMP   = 9'b000000100,
      S_ROOT_RD  = 9'b000001000,
      S_ROOT_CHK = 9'b000010000,
      S_DN_RD    = 9'b000100000,
      S_DN_SEL   = 9'b001000000,
      S_DN_CMP   = 9'b010000000,
      S_RESP     = 9'b100000000
   } state_type;

   state_type                  state_ff, state_in;
   logic [CNT_W-1:0]           count_ff, count_in;
   logic [ADDR_W-1:0]          pos_ff, pos_in;
   logic [ADDR_W-1:0]          child_idx_ff, child_idx_in;
   pes_pkg::entry_type         item_ff, item_in;
   pes_pkg::entry_type         child_ff, child_in;
   logic [pes_pkg::ID_W-1:0]   out_id_ff, out_id_in;
   logic [TIME_W-1:0]          out_time_ff, out_time_in;
   logic [1:0]                 out_status_ff, out_status_in;

   logic                       wr_en;
   logic [ADDR_W-1:0]          wr_addr;
   pes_pkg::entry_type         wr_data;
   logic [ADDR_W-1:0]          rd_addr_a;
   logic [ADDR_W-1:0]          rd_addr_b;
   pes_pkg::entry_type         rd_a;
   pes_pkg::entry_type         rd_b;
   pes_pkg::entry_type         cmp_a;
   pes_pkg::entry_type         cmp_b;
   logic                       a_first;

   logic [ADDR_W-1:0]          parent_idx;
   logic [IDX_W-1:0]           left_idx;
   logic [IDX_W-1:0]           right_idx;
   logic [IDX_W-1:0]           count_ext;
   logic                       left_ok;
   logic                       right_ok;
   logic [TIME_W:0]            due_sum;

   pes_heap_mem #(
      .DEPTH (MAX_ENTRIES)
   ) u_mem (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_addr_a (rd_addr_a),
      .rd_data_a (rd_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_b (rd_b)
   );

   pes_key_cmp u_cmp (
      .a       (cmp_a),
      .b       (cmp_b),
      .a_first (a_first)
   );

   assign parent_idx = ADDR_W'((pos_ff - ADDR_W'(1)) >> 1);
   assign left_idx   = IDX_W'({pos_ff, 1'b1});
   assign right_idx  = left_idx + IDX_W'(1);
   assign count_ext  = IDX_W'(count_ff);
   assign left_ok    = (left_idx < count_ext);
   assign right_ok   = (right_idx < count_ext);
   assign due_sum    = {1'b0, rd_a.due_time} + (TIME_W + 1)'(rd_a.period);

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      pos_in        = pos_ff;
      child_idx_in  = child_idx_ff;
      item_in       = item_ff;
      child_in      = child_ff;
      out_id_in     = out_id_ff;
      out_time_in   = out_time_ff;
      out_status_in = out_status_ff;
      wr_en         = 1'b0;
      wr_addr       = pos_ff;
      wr_data       = item_ff;
      rd_addr_a     = '0;
      rd_addr_b     = right_idx[ADDR_W-1:0];
      cmp_a         = item_ff;
      cmp_b         = rd_a;
      case (state_ff)
         S_IDLE: begin
            if (req_ch.valid) begin
               out_id_in     = '0;
               out_time_in   = '0;
               out_status_in = pes_pkg::ST_OK;
               state_in      = S_RESP;
               case (req_ch.func)
                  pes_pkg::FUNC_CLEAR: begin
                     count_in = '0;
                  end
                  pes_pkg::FUNC_REGISTER: begin
                     if (count_ff == CNT_W'(MAX_ENTRIES)) begin
                        out_status_in = pes_pkg::ST_FULL;
                     end else begin
                        item_in.due_time = TIME_W'(req_ch.period);
                        item_in.user_id  = req_ch.user_id;
                        item_in.period   = req_ch.period;
                        pos_in           = count_ff[ADDR_W-1:0];
                        count_in         = count_ff + CNT_W'(1);
                        state_in         = S_UP_RD;
                     end
                  end
                  pes_pkg::FUNC_NEXT: begin
                     if (count_ff == '0) begin
                        out_status_in = pes_pkg::ST_EMPTY;
                     end else begin
                        state_in = S_ROOT_RD;
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_UP_RD: begin
            if (pos_ff == '0) begin
               wr_en    = 1'b1;
               state_in = S_RESP;
            end else begin
               rd_addr_a = parent_idx;
               state_in  = S_UP_CMP;
            end
         end
         S_UP_CMP: begin
            wr_en = 1'b1;
            if (a_first) begin
               wr_data  = rd_a;
               pos_in   = parent_idx;
               state_in = S_UP_RD;
            end else begin
               state_in = S_RESP;
            end
         end
         S_ROOT_RD: begin
            rd_addr_a = '0;
            state_in  = S_ROOT_CHK;
         end
         S_ROOT_CHK: begin
            if (due_sum[TIME_W]) begin
               out_status_in = pes_pkg::ST_OVERFLOW;
               state_in      = S_RESP;
            end else begin
               out_id_in        = rd_a.user_id;
               out_time_in      = rd_a.due_time;
               item_in.due_time = due_sum[TIME_W-1:0];
               item_in.user_id  = rd_a.user_id;
               item_in.period   = rd_a.period;
               pos_in           = '0;
               state_in         = S_DN_RD;
            end
         end
         S_DN_RD: begin
            if (!left_ok) begin
               wr_en    = 1'b1;
               state_in = S_RESP;
            end else begin
               rd_addr_a = left_idx[ADDR_W-1:0];
               state_in  = S_DN_SEL;
            end
         end
         S_DN_SEL: begin
            cmp_a = rd_b;
            cmp_b = rd_a;
            if (right_ok && a_first) begin
               child_in     = rd_b;
               child_idx_in = right_idx[ADDR_W-1:0];
            end else begin
               child_in     = rd_a;
               child_idx_in = left_idx[ADDR_W-1:0];
            end
            state_in = S_DN_CMP;
         end
         S_DN_CMP: begin
            cmp_a = child_ff;
            cmp_b = item_ff;
            wr_en = 1'b1;
            if (a_first) begin
               wr_data  = child_ff;
               pos_in   = child_idx_ff;
               state_in = S_DN_RD;
            end else begin
               state_in = S_RESP;
            end
         end
         S_RESP: begin
            if (rsp_ch.ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff        <= pos_in;
      child_idx_ff  <= child_idx_in;
      item_ff       <= item_in;
      child_ff      <= child_in;
      out_id_ff     <= out_id_in;
      out_time_ff   <= out_time_in;
      out_status_ff <= out_status_in;
   end

   assign req_ch.ready       = (state_ff == S_IDLE);
   assign rsp_ch.valid       = (state_ff == S_RESP);
   assign rsp_ch.served_id   = out_id_ff;
   assign rsp_ch.served_time = out_time_ff;
   assign rsp_ch.status      = out_status_ff;

`include "periodic_event_scheduler_assert.svh"

   `PES_ASSERT_IMPLY(a_count_bound, clock, reset, 1'b1, count_ff <= CNT_W'(MAX_ENTRIES))
   `PES_ASSERT_IMPLY(a_one_side, clock, reset, req_ch.ready, !rsp_ch.valid)
   `PES_ASSERT_IMPLY(a_zero_fields, clock, reset,
      rsp_ch.valid && rsp_ch.status != pes_pkg::ST_OK,
      rsp_ch.served_id == '0 && rsp_ch.served_time == '0)
   `PES_ASSERT_NEXT(a_empty_next, clock, reset,
      req_ch.valid && req_ch.ready && req_ch.func == pes_pkg::FUNC_NEXT && count_ff == '0,
      rsp_ch.valid && rsp_ch.status == pes_pkg::ST_EMPTY)

endmodule

// ===== rtl/core/pes_heap_mem.sv =====
// ----------------------------------------------------------------------------
// pes_heap_mem
// heap entry storage, one write port and two registered read ports
// ----------------------------------------------------------------------------
module pes_heap_mem #(
   parameter int DEPTH = 64,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [ADDR_W-1:0]   wr_addr,
   input  pes_pkg::entry_type  wr_data,
   input  logic [ADDR_W-1:0]   rd_addr_a,
   output pes_pkg::entry_type  rd_data_a,
   input  logic [ADDR_W-1:0]   rd_addr_b,
   output pes_pkg::entry_type  rd_data_b
);

   pes_pkg::entry_type mem_ff [DEPTH];
   pes_pkg::entry_type rd_a_ff;
   pes_pkg::entry_type rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_a_ff <= mem_ff[rd_addr_a];
      rd_b_ff <= mem_ff[rd_addr_b];
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

// ===== rtl/core/pes_key_cmp.sv =====
// ----------------------------------------------------------------------------
// pes_key_cmp
// shared serve-order comparator: due time, then id, then period
// ----------------------------------------------------------------------------
module pes_key_cmp (
   input  pes_pkg::entry_type a,
   input  pes_pkg::entry_type b,
   output logic               a_first
);

   assign a_first = (a < b);

endmodule
